// File: rtl/core/dtcd_pkg.sv
// ----------------------------------------------------------------------------
// dtcd_pkg
// Shared widths, codes and types of the dual threshold crossing detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dtcd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 32;
  localparam int IV_W       = 32;
  localparam int TIME_W     = 64;
  localparam int CODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // |(|s| - 1.0)| stays below 2^15, |s - prev| below 2^16.
  localparam int DIST_W = 15;
  localparam int VEL_W  = 16;
  // Dividend is dist * interval.
  localparam int NUM_W  = DIST_W + IV_W;
  localparam int CNT_W  = $clog2(NUM_W);

  localparam logic [1:0] PH_UNKNOWN = 2'd0;
  localparam logic [1:0] PH_LOWER   = 2'd1;
  localparam logic [1:0] PH_UPPER   = 2'd2;

  localparam logic [CODE_W-1:0] EV_JUMP_UP     = 3'd0;
  localparam logic [CODE_W-1:0] EV_JUMP_DOWN   = 3'd1;
  localparam logic [CODE_W-1:0] EV_BELOW_LOWER = 3'd2;
  localparam logic [CODE_W-1:0] EV_ABOVE_LOWER = 3'd3;
  localparam logic [CODE_W-1:0] EV_BELOW_UPPER = 3'd4;
  localparam logic [CODE_W-1:0] EV_ABOVE_UPPER = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] UPPER_RST    = 16'sd4096;
  localparam logic signed [SAMPLE_W-1:0] LOWER_RST    = -16'sd4096;
  localparam logic        [IV_W-1:0]     INTERVAL_RST = 32'd16777;
  localparam logic        [17:0]         UNIT_Q12     = 18'd4096;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
    logic [1:0]        phase;
    logic              beyond;
    logic              jump;
    logic [DIST_W-1:0] gap;
    logic [VEL_W-1:0]  vel;
  } cls_t;

endpackage

`default_nettype wire

// File: rtl/core/dtcd_classify.sv
// ----------------------------------------------------------------------------
// dtcd_classify
// Well classification of one sample and the interpolation operands.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcd_classify
  import dtcd_pkg::*;
(
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic signed [SAMPLE_W-1:0] prev_i,
  input  wire logic        [1:0]          phase_i,
  input  wire logic                       beyond_i,
  input  wire logic signed [SAMPLE_W-1:0] upper_i,
  input  wire logic signed [SAMPLE_W-1:0] lower_i,
  output cls_t                            cls_o
);

  logic [16:0] mag;
  logic [17:0] dist_s;
  logic [17:0] dist_a;
  logic [16:0] vel_s;
  logic [16:0] vel_a;

  always_comb begin
    mag    = sample_i[SAMPLE_W-1] ? (17'd0 - {sample_i[SAMPLE_W-1], sample_i})
                                  : {1'b0, sample_i};
    dist_s = {1'b0, mag} - UNIT_Q12;
    dist_a = dist_s[17] ? (18'd0 - dist_s) : dist_s;
    vel_s  = {sample_i[SAMPLE_W-1], sample_i} - {prev_i[SAMPLE_W-1], prev_i};
    vel_a  = vel_s[16] ? (17'd0 - vel_s) : vel_s;
  end

  always_comb begin
    cls_o        = '0;
    cls_o.phase  = phase_i;
    cls_o.beyond = beyond_i;
    cls_o.gap    = dist_a[DIST_W-1:0];
    cls_o.vel    = vel_a[VEL_W-1:0];
    unique case (phase_i)
      PH_LOWER: begin
        priority if (sample_i >= upper_i) begin
          cls_o.phase  = PH_UPPER;
          cls_o.beyond = 1'b1;
          cls_o.jump   = 1'b1;
          cls_o.hit    = 1'b1;
          cls_o.code   = EV_JUMP_UP;
        end else if (sample_i < lower_i && beyond_i) begin
          cls_o.beyond = 1'b0;
          cls_o.hit    = 1'b1;
          cls_o.code   = EV_BELOW_LOWER;
        end else if (sample_i > lower_i && !beyond_i) begin
          cls_o.beyond = 1'b1;
          cls_o.hit    = 1'b1;
          cls_o.code   = EV_ABOVE_LOWER;
        end
      end
      PH_UPPER: begin
        priority if (sample_i <= lower_i) begin
          cls_o.phase  = PH_LOWER;
          cls_o.beyond = 1'b0;
          cls_o.jump   = 1'b1;
          cls_o.hit    = 1'b1;
          cls_o.code   = EV_JUMP_DOWN;
        end else if (sample_i < upper_i && beyond_i) begin
          cls_o.beyond = 1'b0;
          cls_o.hit    = 1'b1;
          cls_o.code   = EV_BELOW_UPPER;
        end else if (sample_i > upper_i && !beyond_i) begin
          cls_o.beyond = 1'b1;
          cls_o.hit    = 1'b1;
          cls_o.code   = EV_ABOVE_UPPER;
        end
      end
      default: begin
        // Start point not yet known: no event until a sample lies below the lower bound or above the upper bound.
        priority if (sample_i < lower_i) begin
          cls_o.phase  = PH_LOWER;
          cls_o.beyond = 1'b0;
        end else if (sample_i > upper_i) begin
          cls_o.phase  = PH_UPPER;
          cls_o.beyond = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/dtcd_div.sv
// ----------------------------------------------------------------------------
// dtcd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcd_div
  import dtcd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] dividend_i,
  input  wire logic [VEL_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quotient_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] dq_q, dq_d;
  logic [VEL_W-1:0] rem_q, rem_d;
  logic [VEL_W-1:0] dvs_q, dvs_d;
  logic [VEL_W:0]   trial;
  logic [VEL_W:0]   diff;
  logic             ge;

  always_comb begin
    // The dividend shifts out at the top while quotient bits shift in below.
    trial  = {rem_q, dq_q[NUM_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W - 1);
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[NUM_W-2:0], ge};
      rem_d = ge ? diff[VEL_W-1:0] : trial[VEL_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

`default_nettype wire

// File: rtl/core/dual_threshold_crossing_detector_unit.sv
// ----------------------------------------------------------------------------
// dual_threshold_crossing_detector_unit
// Hysteresis crossing detector with interpolated event times.
// ----------------------------------------------------------------------------
// A sample that raises no event is taken without a stall and the next request can
// follow in the cycle after. A sample that raises an event keeps the input
// stalled while its time is worked out: two passes through the one 32x32
// multiplier (index times interval, then distance times interval), then the
// bit-serial divider for the correction, skipped when the velocity is zero,
// and a final subtract with saturation; the stall lasts until the output
// register is free. A finished event waits in the output register,
// and a new sample may be taken while it waits.
`default_nettype none

module dual_threshold_crossing_detector_unit
  import dtcd_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       restart_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [CODE_W-1:0]               event_code_o,
  output logic [IDX_W-1:0]                sample_index_o,
  output logic signed [TIME_W-1:0]        crossing_time_o,
  output logic [IDX_W-1:0]                jump_count_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_BASE = 3'd1;
  localparam logic [2:0] ST_MUL_CORR = 3'd2;
  localparam logic [2:0] ST_DIV      = 3'd3;
  localparam logic [2:0] ST_FIN      = 3'd4;

  localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

  logic [2:0] state_q, state_d;

  logic signed [SAMPLE_W-1:0] upper_q, lower_q;
  logic        [IV_W-1:0]     interval_q;

  logic [1:0]                 phase_q;
  logic                       beyond_q;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic [IDX_W-1:0]           index_q;
  logic [IDX_W-1:0]           jumps_q;

  logic [1:0]                 phase_eff;
  logic                       beyond_eff;
  logic signed [SAMPLE_W-1:0] prev_eff;
  logic [IDX_W-1:0]           index_eff;
  logic [IDX_W-1:0]           jumps_eff;
  logic [IDX_W-1:0]           jumps_new;
  cls_t                       cls;
  logic                       in_acc;
  logic                       out_free;

  logic [CODE_W-1:0] ev_code_q;
  logic [IDX_W-1:0]  ev_idx_q;
  logic [IDX_W-1:0]  ev_jumps_q;
  logic [DIST_W-1:0] dist_q;
  logic [VEL_W-1:0]  vel_q;
  logic [TIME_W-1:0] base_q;
  logic [NUM_W-1:0]  corr_q;

  logic [IV_W-1:0]   mul_a;
  logic [TIME_W-1:0] product;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  quotient;
  logic [TIME_W:0]   tdiff;
  logic [TIME_W-1:0] ctime;

  logic                    out_valid_q;
  logic [CODE_W-1:0]       out_code_q;
  logic [IDX_W-1:0]        out_idx_q;
  logic [TIME_W-1:0]       out_time_q;
  logic [IDX_W-1:0]        out_jumps_q;

  // A restart clears the trajectory state before this sample is classified.
  always_comb begin
    phase_eff  = restart_i ? PH_UNKNOWN : phase_q;
    beyond_eff = restart_i ? 1'b0 : beyond_q;
    prev_eff   = restart_i ? '0 : prev_q;
    index_eff  = restart_i ? '0 : index_q;
    jumps_eff  = restart_i ? '0 : jumps_q;
    jumps_new  = (cls.jump && (jumps_eff != '1)) ? jumps_eff + 1'b1 : jumps_eff;
  end

  dtcd_classify u_classify (
    .sample_i (sample_i),
    .prev_i   (prev_eff),
    .phase_i  (phase_eff),
    .beyond_i (beyond_eff),
    .upper_i  (upper_q),
    .lower_i  (lower_q),
    .cls_o    (cls)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // The one multiplier serves both products in turn.
  assign mul_a     = (state_q == ST_MUL_BASE) ? ev_idx_q : {{(IV_W-DIST_W){1'b0}}, dist_q};
  assign product   = TIME_W'(mul_a) * TIME_W'(interval_q);
  assign div_start = (state_q == ST_MUL_CORR) && (vel_q != '0);

  dtcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product[NUM_W-1:0]),
    .divisor_i  (vel_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // A borrow means a negative time, which wraps; otherwise a result above the signed maximum clips to it.
  always_comb begin
    tdiff = {1'b0, base_q} - {{(TIME_W+1-NUM_W){1'b0}}, corr_q};
    ctime = (!tdiff[TIME_W] && tdiff[TIME_W-1]) ? TIME_MAX : tdiff[TIME_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_acc && cls.hit) state_d = ST_MUL_BASE;
      ST_MUL_BASE: state_d = ST_MUL_CORR;
      ST_MUL_CORR: state_d = (vel_q == '0) ? ST_FIN : ST_DIV;
      ST_DIV:      if (div_done) state_d = ST_FIN;
      ST_FIN:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      upper_q     <= UPPER_RST;
      lower_q     <= LOWER_RST;
      interval_q  <= INTERVAL_RST;
      phase_q     <= PH_UNKNOWN;
      beyond_q    <= 1'b0;
      prev_q      <= '0;
      index_q     <= '0;
      jumps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_UPPER:    upper_q    <= cfg_data_i[SAMPLE_W-1:0];
          REG_LOWER:    lower_q    <= cfg_data_i[SAMPLE_W-1:0];
          REG_INTERVAL: interval_q <= cfg_data_i[IV_W-1:0];
          default:      ;
        endcase
      end
      if (in_acc) begin
        phase_q  <= cls.phase;
        beyond_q <= cls.beyond;
        prev_q   <= sample_i;
        index_q  <= index_eff + 1'b1;
        jumps_q  <= jumps_new;
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ev_code_q  <= cls.code;
      ev_idx_q   <= index_eff;
      ev_jumps_q <= jumps_new;
      dist_q     <= cls.gap;
      vel_q      <= cls.vel;
    end
    if (state_q == ST_MUL_BASE) begin
      base_q <= product;
    end
    if (state_q == ST_MUL_CORR) begin
      corr_q <= '0;
    end else if (state_q == ST_DIV && div_done) begin
      corr_q <= quotient;
    end
    if (state_q == ST_FIN && out_free) begin
      out_code_q  <= ev_code_q;
      out_idx_q   <= ev_idx_q;
      out_time_q  <= ctime;
      out_jumps_q <= ev_jumps_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_code_o    = out_code_q;
  assign sample_index_o  = out_idx_q;
  assign crossing_time_o = out_time_q;
  assign jump_count_o    = out_jumps_q;

endmodule

`default_nettype wire
